/* hw/rtl/sorted_interval_table_point_query_assert.svh */
// assertion macros shared by the interval table rtl
// no dependencies; included by modules that carry concurrent checks
`ifndef SORTED_INTERVAL_TABLE_POINT_QUERY_ASSERT_SVH
`define SORTED_INTERVAL_TABLE_POINT_QUERY_ASSERT_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define SITPQ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition in one cycle implies a condition in the next cycle
`define SITPQ_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define SITPQ_ASSERT(label, clk, rst, prop, msg)
`define SITPQ_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

/* hw/rtl/sitpq_pkg.sv */
// shared constants, codes and types of the interval table
// no dependencies; imported by every module of the block but the ram
package sitpq_pkg;

  // sizing
  localparam int NUM_LISTS   = 6;
  localparam int MAX_ENTRIES = 256;
  localparam int SEL_W       = 3;
  localparam int TIME_W      = 32;
  localparam int TICK_W      = 31;
  localparam int END_W       = TICK_W + 1;
  localparam int DATA_W      = 2 * TICK_W;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int DEPTH       = NUM_LISTS * MAX_ENTRIES;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int LIST_W      = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;

  // operation codes
  localparam logic [1:0] OP_ADD     = 2'd0;
  localparam logic [1:0] OP_QUERY   = 2'd1;
  localparam logic [1:0] OP_CLR_ALL = 2'd2;
  localparam logic [1:0] OP_CLR_ONE = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ORDER = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // update of the per-list count and last start time
  typedef struct packed {
    logic              clr_all;
    logic              clr_one;
    logic              add;
    logic [SEL_W-1:0]  sel;
    logic [TIME_W-1:0] start_time;
  } list_upd_t;

  // access to the interval memory
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  // finished result handed to the output register
  typedef struct packed {
    logic       valid;
    logic       hit;
    logic [1:0] status;
  } result_t;

endpackage

/* hw/rtl/sitpq_ram.sv */
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module sitpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/sitpq_lists.sv */
// per-list fill count and last start time
// depends on sitpq_pkg
module sitpq_lists import sitpq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  list_upd_t         upd,
  input  logic [SEL_W-1:0]  rd_sel,
  output logic [CNT_W-1:0]  rd_count,
  output logic [TIME_W-1:0] rd_last
);

  logic [CNT_W-1:0]  count [NUM_LISTS];
  logic [TIME_W-1:0] last  [NUM_LISTS];
  logic              rd_ok;

  // lookup of the addressed list
  assign rd_ok    = (32'(rd_sel) < 32'(NUM_LISTS));
  assign rd_count = rd_ok ? count[LIST_W'(rd_sel)] : '0;
  assign rd_last  = rd_ok ? last[LIST_W'(rd_sel)] : '0;

  // append and clear
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        count[i] <= '0;
        last[i]  <= '0;
      end
    end else if (upd.clr_all) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        count[i] <= '0;
        last[i]  <= '0;
      end
    end else if (upd.clr_one) begin
      count[LIST_W'(upd.sel)] <= '0;
      last[LIST_W'(upd.sel)]  <= '0;
    end else if (upd.add) begin
      count[LIST_W'(upd.sel)] <= count[LIST_W'(upd.sel)] + CNT_W'(1);
      last[LIST_W'(upd.sel)]  <= upd.start_time;
    end
  end

endmodule

/* hw/rtl/sitpq_ctrl.sv */
// transaction sequencer: add, clear and the binary search over the interval ram
// depends on sitpq_pkg and the assertion macro header
`include "sorted_interval_table_point_query_assert.svh"

module sitpq_ctrl import sitpq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        op,
  input  logic [SEL_W-1:0]  list_sel,
  input  logic [TIME_W-1:0] start_time,
  input  logic [TICK_W-1:0] tick_value,
  input  logic [TICK_W-1:0] length_ticks,
  input  logic [CNT_W-1:0]  lst_count,
  input  logic [TIME_W-1:0] lst_last,
  output list_upd_t         upd,
  output ram_req_t          ram_req,
  input  logic [DATA_W-1:0] rd_data,
  output result_t           res,
  input  logic              res_take
);

  localparam int SPAN_W = CNT_W + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PROBE = 3'd1;
  localparam logic [2:0] S_EVAL  = 3'd2;
  localparam logic [2:0] S_FCHK  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]        state, state_next;
  logic [CNT_W-1:0]  first, first_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [CNT_W-1:0]  step, step_next;
  logic [CNT_W-1:0]  limit, limit_next;
  logic [ADDR_W-1:0] base, base_next;
  logic [TICK_W-1:0] tick, tick_next;
  logic              res_inside, res_inside_next;
  logic [1:0]        res_status, res_status_next;

  logic              accept;
  logic              sel_ok;
  logic [ADDR_W-1:0] in_base;
  logic [TICK_W-1:0] rd_start;
  logic [TICK_W-1:0] rd_dur;
  logic [END_W-1:0]  rd_end;
  logic              end_below;
  logic [SPAN_W-1:0] span;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign sel_ok   = (32'(list_sel) < 32'(NUM_LISTS));
  assign in_base  = ADDR_W'(32'(list_sel) * MAX_ENTRIES);

  // end of the interval read back from ram
  assign rd_start  = rd_data[DATA_W-1:TICK_W];
  assign rd_dur    = rd_data[TICK_W-1:0];
  assign rd_end    = END_W'(rd_start) + END_W'(rd_dur);
  assign end_below = rd_end < END_W'(tick);

  assign span = SPAN_W'(first) + SPAN_W'(cnt);

  // sequencer
  always_comb begin
    state_next      = state;
    first_next      = first;
    cnt_next        = cnt;
    step_next       = step;
    limit_next      = limit;
    base_next       = base;
    tick_next       = tick;
    res_inside_next = res_inside;
    res_status_next = res_status;
    upd             = '0;
    upd.sel         = list_sel;
    upd.start_time  = start_time;
    ram_req         = '0;
    ram_req.waddr   = in_base + ADDR_W'(lst_count);
    ram_req.wdata   = {tick_value, length_ticks};
    ram_req.raddr   = base + ADDR_W'(first);
    res             = '0;
    res.hit         = res_inside;
    res.status      = res_status;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_inside_next = 1'b0;
          res_status_next = ST_OK;
          state_next      = S_DONE;
          case (op)
            OP_ADD: begin
              if (sel_ok) begin
                if (lst_count >= CNT_W'(MAX_ENTRIES)) begin
                  res_status_next = ST_FULL;
                end else begin
                  ram_req.we = 1'b1;
                  upd.add    = 1'b1;
                  if (lst_count != '0 && start_time <= lst_last) begin
                    res_status_next = ST_ORDER;
                  end
                end
              end
            end
            OP_QUERY: begin
              if (sel_ok && lst_count != '0) begin
                first_next = '0;
                cnt_next   = lst_count;
                limit_next = lst_count;
                base_next  = in_base;
                tick_next  = tick_value;
                state_next = S_PROBE;
              end
            end
            OP_CLR_ALL: begin
              upd.clr_all = 1'b1;
            end
            default: begin
              upd.clr_one = sel_ok;
            end
          endcase
        end
      end
      S_PROBE: begin
        if (cnt != '0) begin
          // probe the middle of the remaining range
          step_next     = cnt >> 1;
          ram_req.re    = 1'b1;
          ram_req.raddr = base + ADDR_W'(first) + ADDR_W'(cnt >> 1);
          state_next    = S_EVAL;
        end else if (first >= limit) begin
          state_next = S_DONE;
        end else begin
          // fetch the candidate for the containment test
          ram_req.re = 1'b1;
          state_next = S_FCHK;
        end
      end
      S_EVAL: begin
        if (end_below) begin
          first_next = first + step + CNT_W'(1);
          cnt_next   = cnt - step - CNT_W'(1);
        end else begin
          cnt_next = step;
        end
        state_next = S_PROBE;
      end
      S_FCHK: begin
        res_inside_next = (rd_start <= tick) && (END_W'(tick) <= rd_end);
        state_next      = S_DONE;
      end
      S_DONE: begin
        res.valid = 1'b1;
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // search and result registers
  always_ff @(posedge clk) begin
    first      <= first_next;
    cnt        <= cnt_next;
    step       <= step_next;
    limit      <= limit_next;
    base       <= base_next;
    tick       <= tick_next;
    res_inside <= res_inside_next;
    res_status <= res_status_next;
  end

  // checks
  `SITPQ_ASSERT(a_write_on_add, clk, rst, ram_req.we |-> (accept && op == OP_ADD), "ram write without an accepted add")
  `SITPQ_ASSERT(a_no_rw_overlap, clk, rst, !(ram_req.we && ram_req.re), "ram read and write in the same cycle")
  `SITPQ_ASSERT(a_probe_span, clk, rst, (state == S_PROBE) |-> (span <= SPAN_W'(limit)), "search range runs past the list fill")
  `SITPQ_ASSERT_NEXT(a_read_used, clk, rst, ram_req.re, (state == S_EVAL || state == S_FCHK), "ram read data not consumed")
  `SITPQ_ASSERT(a_count_bound, clk, rst, lst_count <= CNT_W'(MAX_ENTRIES), "list fill above capacity")

endmodule

/* hw/rtl/sorted_interval_table_point_query.sv */
// Interval table with point query. Holds NUM_LISTS lists of up to MAX_ENTRIES
// intervals (start tick, duration) in one synchronous ram with registered
// read; per-list fill counts and last start times sit in flip-flops.
// One transaction is in work at a time. Add, clear and transactions on an
// out-of-range list go straight from acceptance to the done state. A query on
// a list of n entries makes up to P = floor(log2(n)) + 1 lower-bound probes
// (P = 9 at 256 entries), then a containment test: each probe is a ram read
// in the probe state and a comparison of the interval end in the eval state.
// The next transaction is accepted while a finished result still waits at
// the output. The interval ram needs no clearing pass after reset; only
// entries below a list's fill count are ever read.
// depends on sitpq_pkg, sitpq_ram, sitpq_lists, sitpq_ctrl
module sorted_interval_table_point_query import sitpq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        op,
  input  logic [SEL_W-1:0]  list_sel,
  input  logic [TIME_W-1:0] start_time,
  input  logic [TICK_W-1:0] tick_value,
  input  logic [TICK_W-1:0] length_ticks,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              inside_res,
  output logic [1:0]        status
);

  list_upd_t         upd;
  ram_req_t          ram_req;
  result_t           res;
  logic [CNT_W-1:0]  lst_count;
  logic [TIME_W-1:0] lst_last;
  logic [DATA_W-1:0] rd_data;
  logic              res_take;

  // per-list state
  sitpq_lists u_lists (
    .clk      (clk),
    .rst      (rst),
    .upd      (upd),
    .rd_sel   (list_sel),
    .rd_count (lst_count),
    .rd_last  (lst_last)
  );

  // interval store: start tick above duration
  sitpq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rd_data)
  );

  // sequencer
  sitpq_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .list_sel     (list_sel),
    .start_time   (start_time),
    .tick_value   (tick_value),
    .length_ticks (length_ticks),
    .lst_count    (lst_count),
    .lst_last     (lst_last),
    .upd          (upd),
    .ram_req      (ram_req),
    .rd_data      (rd_data),
    .res          (res),
    .res_take     (res_take)
  );

  // output register
  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid && res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_take) begin
      inside_res <= res.hit;
      status     <= res.status;
    end
  end

endmodule

/* verif/sorted_interval_table_point_query_checker.sv */
// checker for the interval table: predicts every transaction result and compares it
// depends on sitpq_pkg; watches both channels of sorted_interval_table_point_query
module sorted_interval_table_point_query_checker import sitpq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        op,
  input  logic [SEL_W-1:0]  list_sel,
  input  logic [TIME_W-1:0] start_time,
  input  logic [TICK_W-1:0] tick_value,
  input  logic [TICK_W-1:0] length_ticks,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              inside_res,
  input  logic [1:0]        status,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic       hit;
    logic [1:0] status;
  } outcome_t;

  // shadow of the table contents
  logic [CNT_W-1:0]  fill_count [NUM_LISTS];
  logic [TIME_W-1:0] last_time  [NUM_LISTS];
  logic [TICK_W-1:0] iv_start   [DEPTH];
  logic [TICK_W-1:0] iv_len     [DEPTH];
  outcome_t          expected_q [$];
  int                errors = 0;

  // end tick of a stored interval, one bit wider than a tick
  function automatic logic [END_W-1:0] interval_end(int idx);
    return {1'b0, iv_start[idx]} + {1'b0, iv_len[idx]};
  endfunction

  // lower-bound search on interval ends, then inclusive containment test
  function automatic logic tick_inside(int sel, logic [TICK_W-1:0] tick);
    int base;
    int first;
    int count;
    int step;
    base  = sel * MAX_ENTRIES;
    first = 0;
    count = int'(fill_count[sel]);
    while (count > 0) begin
      step = count / 2;
      if (interval_end(base + first + step) < {1'b0, tick}) begin
        first = first + step + 1;
        count = count - step - 1;
      end else begin
        count = step;
      end
    end
    if (first >= int'(fill_count[sel])) return 1'b0;
    return (iv_start[base + first] <= tick) && ({1'b0, tick} <= interval_end(base + first));
  endfunction

  // predicted effect of one transaction on the table and its result
  function automatic outcome_t apply_transaction(logic [1:0] code, logic [SEL_W-1:0] sel,
                                                 logic [TIME_W-1:0] st,
                                                 logic [TICK_W-1:0] tk,
                                                 logic [TICK_W-1:0] len);
    outcome_t res;
    int       n;
    int       idx;
    res = '0;
    case (code)
      OP_ADD: begin
        if (sel < NUM_LISTS) begin
          n = int'(fill_count[sel]);
          if (n >= MAX_ENTRIES) begin
            res.status = ST_FULL;
          end else begin
            if (n != 0 && st <= last_time[sel]) res.status = ST_ORDER;
            idx = int'(sel) * MAX_ENTRIES + n;
            iv_start[idx]   = tk;
            iv_len[idx]     = len;
            last_time[sel]  = st;
            fill_count[sel] = CNT_W'(n + 1);
          end
        end
      end
      OP_QUERY: begin
        if (sel < NUM_LISTS) res.hit = tick_inside(int'(sel), tk);
      end
      OP_CLR_ALL: begin
        for (int i = 0; i < NUM_LISTS; i++) begin
          fill_count[i] = '0;
          last_time[i]  = '0;
        end
      end
      default: begin
        if (sel < NUM_LISTS) begin
          fill_count[sel] = '0;
          last_time[sel]  = '0;
        end
      end
    endcase
    return res;
  endfunction

  // compare accepted results, then predict accepted transactions
  always @(posedge clk) begin
    outcome_t want;
    outcome_t predicted;
    if (rst) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        fill_count[i] = '0;
        last_time[i]  = '0;
      end
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual inside_res=%0b status=%0d",
                   $time, inside_res, status);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (inside_res !== want.hit) begin
            $display("%0t: inside_res mismatch, expected %0b, actual %0b",
                     $time, want.hit, inside_res);
            errors++;
          end
          if (status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, status);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        predicted  = apply_transaction(op, list_sel, start_time, tick_value, length_ticks);
        expected_q = {expected_q, predicted};
      end
    end
    fail_count <= errors;
    pending    <= expected_q.size();
  end

endmodule

/* verif/sorted_interval_table_point_query_test.sv */
// testbench top for the interval table: reset, clock, stimulus, receiver stalls, verdict
// depends on sitpq_pkg, sorted_interval_table_point_query and its checker module
module sorted_interval_table_point_query_test import sitpq_pkg::*;;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic [TICK_W-1:0] TICK_MAX = '1;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              in_valid     = 1'b0;
  logic              in_stall;
  logic [1:0]        op           = OP_ADD;
  logic [SEL_W-1:0]  list_sel     = '0;
  logic [TIME_W-1:0] start_time   = '0;
  logic [TICK_W-1:0] tick_value   = '0;
  logic [TICK_W-1:0] length_ticks = '0;
  logic              out_valid;
  logic              out_stall    = 1'b0;
  logic              inside_res;
  logic [1:0]        status;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int gap_mode    = 1;
  int stall_mode  = 1;
  int stall_left  = 0;

  // per-list cursors that keep generated adds in time and tick order
  logic [TICK_W-1:0] tick_cursor [8];
  logic [TIME_W-1:0] time_cursor [8];

  always #5 clk = ~clk;

  sorted_interval_table_point_query u_top (
    .clk, .rst, .in_valid, .in_stall, .op, .list_sel, .start_time, .tick_value,
    .length_ticks, .out_valid, .out_stall, .inside_res, .status
  );

  sorted_interval_table_point_query_checker u_checker (
    .clk, .rst, .in_valid, .in_stall, .op, .list_sel, .start_time, .tick_value,
    .length_ticks, .out_valid, .out_stall, .inside_res, .status, .fail_count, .pending
  );

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver stalls: mostly short, a few long, no new ones when stall_mode is 0
  always @(posedge clk) begin
    int roll;
    roll = $urandom_range(0, 99);
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (rst || stall_mode == 0) begin
      out_stall <= 1'b0;
    end else if (roll < ((stall_mode == 2) ? 25 : 8)) begin
      out_stall  <= 1'b1;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 50) : $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // idle cycles before the next transaction
  function automatic int sender_gap();
    int roll;
    if (gap_mode == 0) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // present one transaction and hold it until accepted
  task automatic send(input logic [1:0] code, input int sel, input logic [TIME_W-1:0] st,
                      input logic [TICK_W-1:0] tk, input logic [TICK_W-1:0] len);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= code;
    list_sel     <= SEL_W'(sel);
    start_time   <= st;
    tick_value   <= tk;
    length_ticks <= len;
    do @(posedge clk); while (in_stall);
  endtask

  // hold off the sender until every expected result has come back
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // restart the cursors of one list, sometimes near the top of the ranges
  task automatic restart_cursor(input int sel);
    tick_cursor[sel] = ($urandom_range(0, 3) == 0) ? TICK_MAX - 31'h1000 : '0;
    time_cursor[sel] = ($urandom_range(0, 3) == 0) ? 32'hFFFF_F000 : '0;
  endtask

  // add in start order, now and then out of order
  task automatic add_in_order(input int sel);
    logic [TIME_W-1:0] st;
    logic [TICK_W-1:0] tk;
    logic [TICK_W-1:0] len;
    st = time_cursor[sel] + $urandom_range(1, 2000);
    if ($urandom_range(0, 19) == 0) st = time_cursor[sel] - $urandom_range(0, 3);
    tk  = tick_cursor[sel] + TICK_W'($urandom_range(0, 12));
    len = ($urandom_range(0, 9) == 0) ? '0 : TICK_W'($urandom_range(1, 40));
    time_cursor[sel] = st;
    tick_cursor[sel] = tk + len;
    send(OP_ADD, sel, st, tk, len);
  endtask

  // query a tick inside or around the intervals of a list
  task automatic query_near(input int sel);
    int                roll;
    logic [TICK_W-1:0] tk;
    roll = $urandom_range(0, 99);
    if (roll < 10) tk = TICK_W'($urandom);
    else if (roll < 55) tk = TICK_W'($urandom_range(0, tick_cursor[sel] + 20));
    else tk = TICK_W'(tick_cursor[sel] + 5 - $urandom_range(0, 400));
    send(OP_QUERY, sel, $urandom, tk, TICK_W'($urandom));
  endtask

  // one random transaction: mostly ordered adds and queries, some clears and noise
  task automatic random_transaction();
    int roll;
    int sel;
    roll = $urandom_range(0, 99);
    sel  = ($urandom_range(0, 19) == 0) ? $urandom_range(NUM_LISTS, 7)
                                        : $urandom_range(0, NUM_LISTS - 1);
    if (roll < 48) begin
      add_in_order(sel);
    end else if (roll < 82) begin
      query_near(sel);
    end else if (roll < 86) begin
      send(OP_CLR_ONE, sel, $urandom, TICK_W'($urandom), TICK_W'($urandom));
      restart_cursor(sel);
    end else if (roll < 88) begin
      send(OP_CLR_ALL, $urandom_range(0, 7), $urandom, TICK_W'($urandom), TICK_W'($urandom));
      for (int i = 0; i < 8; i++) restart_cursor(i);
    end else begin
      send(2'($urandom_range(0, 3)), $urandom_range(0, 7), $urandom, TICK_W'($urandom),
           TICK_W'($urandom));
    end
  endtask

  initial begin
    for (int i = 0; i < 8; i++) begin
      tick_cursor[i] = '0;
      time_cursor[i] = '0;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty list, zero and maximum fields, order error, touching ends
    send(OP_QUERY,   0, 32'h0, 31'd0, 31'd0);
    send(OP_ADD,     0, 32'h0, 31'd0, 31'd0);
    send(OP_QUERY,   0, 32'h0, 31'd0, 31'd0);
    send(OP_QUERY,   0, 32'h0, 31'd1, 31'd0);
    send(OP_ADD,     0, 32'h0, 31'd100, 31'd50);
    send(OP_ADD,     0, 32'hFFFF_FFFF, TICK_MAX, TICK_MAX);
    send(OP_QUERY,   0, 32'hFFFF_FFFF, TICK_MAX, TICK_MAX);
    send(OP_QUERY,   0, 32'h0, 31'd150, 31'd0);
    send(OP_QUERY,   0, 32'h0, 31'd99, 31'd0);
    send(OP_QUERY,   0, 32'h0, 31'd151, 31'd0);
    send(OP_ADD,     5, 32'd5, 31'd10, 31'd5);
    send(OP_ADD,     6, 32'hFFFF_FFFF, TICK_MAX, TICK_MAX);
    send(OP_QUERY,   7, 32'hFFFF_FFFF, TICK_MAX, TICK_MAX);
    send(OP_CLR_ONE, 7, 32'h0, 31'd0, 31'd0);
    send(OP_ADD,     5, 32'd3, 31'd20, 31'd1);
    send(OP_QUERY,   5, 32'h0, 31'd15, 31'd0);
    send(OP_CLR_ONE, 5, 32'h0, 31'd0, 31'd0);
    send(OP_QUERY,   5, 32'h0, 31'd10, 31'd0);
    send(OP_ADD,     5, 32'h0, 31'd10, 31'd5);
    send(OP_CLR_ALL, 7, 32'h0, 31'd0, 31'd0);
    send(OP_QUERY,   0, 32'h0, 31'd0, 31'd0);
    send(OP_QUERY,   5, 32'h0, 31'd12, 31'd0);
    wait_for_drain();

    // random mix with idling on both sides
    repeat (300) random_transaction();
    wait_for_drain();

    // fill one list past capacity with no idling, queries in between
    gap_mode   = 0;
    stall_mode = 0;
    send(OP_CLR_ONE, 2, $urandom, TICK_W'($urandom), TICK_W'($urandom));
    tick_cursor[2] = '0;
    time_cursor[2] = '0;
    for (int i = 0; i < MAX_ENTRIES + 6; i++) begin
      add_in_order(2);
      if (i % 9 == 0) query_near(2);
    end
    gap_mode   = 1;
    stall_mode = 1;
    repeat (20) query_near(2);

    // random mix under heavy receiver stalls
    stall_mode = 2;
    repeat (240) random_transaction();

    wait_for_drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/sitpq_pkg.sv
hw/rtl/sitpq_ram.sv
hw/rtl/sitpq_lists.sv
hw/rtl/sitpq_ctrl.sv
hw/rtl/sorted_interval_table_point_query.sv
verif/sorted_interval_table_point_query_checker.sv
verif/sorted_interval_table_point_query_test.sv
